@@ rtl/size_keyed_buffer_pool_defines.svh @@
// Assertion macros shared by the buffer pool RTL.
// Included by modules that carry concurrent assertions; expects clk and arst_n in scope.
`ifndef SIZE_KEYED_BUFFER_POOL_DEFINES_SVH
`define SIZE_KEYED_BUFFER_POOL_DEFINES_SVH
`ifndef ASSERT_OFF
`define SKBP_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");
`define SKBP_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`else
`define SKBP_ASSERT(label, expr)
`define SKBP_ASSERT_IMP(label, pre, post)
`endif
`endif

@@ rtl/skbp_pkg.sv @@
// Shared types and codes for the size keyed buffer pool.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps
`default_nettype none
package skbp_pkg;
	localparam int SIZE_W = 16;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic              scan_clr;
		logic              take;
		logic              wr_en;
		logic              free_en;
		logic [SIZE_W-1:0] req_size;
	} cell_ctl_t;
endpackage
`default_nettype wire

@@ rtl/skbp_cell.sv @@
// One pool entry: stored size, busy mark and the scan token stage.
// Depends on skbp_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none
module skbp_cell
	import skbp_pkg::*;
#(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cell_ctl_t     ctl,
	input  wire logic [IW-1:0] wr_idx,
	input  wire logic [IW-1:0] free_idx,
	input  wire logic          tok_i,
	output logic               tok_o,
	output logic               match_o
);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [SIZE_W-1:0] size_q;
	logic              busy_q;
	logic              tok_q;
	logic              wr_here;

	assign wr_here = ctl.wr_en && (wr_idx == MY_IDX);

	always_ff @(posedge clk) begin
		if (wr_here) begin
			size_q <= ctl.req_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= ctl.scan_clr ? 1'b0 : tok_i;
			priority if (wr_here) begin
				busy_q <= 1'b1;
			end else if (ctl.take && tok_q) begin
				busy_q <= 1'b1;
			end else if (ctl.free_en && (free_idx == MY_IDX)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign tok_o   = tok_q;
	assign match_o = tok_q && !busy_q && (size_q == ctl.req_size);
endmodule
`default_nettype wire

@@ rtl/size_keyed_buffer_pool.sv @@
// Top level of the size keyed buffer pool: request sequencer and the row of entry cells.
// Depends on skbp_pkg, skbp_cell and size_keyed_buffer_pool_defines.svh.
//
// Usage: requests arrive on the input valid/ready channel (op, size, handle) and each
// transaction produces exactly one result on the output valid/ready channel.
// A get sends a token down the row of cells, one cell per cycle, and stops at the
// first free entry of the requested (clamped) size or at the end of the created entries.
// A get registers its result when the token stops, and a put registers its result in the
// cycle after it is accepted. One request is in flight at a time.
// The result register is the only output stage; a new request is taken once it is empty
// or being read in the same cycle, so puts can follow one per cycle while the receiver
// reads each result. While the receiver stalls, the result holds and no new request is
// taken. Reset clears all busy marks, the entry count and both counters; entry sizes are
// written when an entry is created.
`timescale 1ns / 1ps
`default_nettype none
`include "size_keyed_buffer_pool_defines.svh"
module size_keyed_buffer_pool
	import skbp_pkg::*;
#(
	parameter int ENTRIES  = 64,
	parameter int MAX_SIZE = 32768,
	parameter int IW       = $clog2(ENTRIES),
	parameter int CW       = $clog2(ENTRIES + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire logic [SIZE_W-1:0] size,
	input  wire logic [IW-1:0]     handle,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [IW-1:0]          granted_handle,
	output logic                   hit,
	output logic [1:0]             status,
	output logic [31:0]            hit_total,
	output logic [31:0]            miss_total,
	output logic [CW-1:0]          entries_used
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [20:0] MAX_W = 21'(MAX_SIZE);
	localparam logic [CW-1:0] FULL_COUNT = CW'(ENTRIES);

	logic [1:0]        state_q;
	logic [CW-1:0]     scan_idx_q;
	logic [CW-1:0]     count_q;
	logic [31:0]       hit_q;
	logic [31:0]       miss_q;
	logic [SIZE_W-1:0] req_q;
	logic              out_valid_q;
	logic [IW-1:0]     granted_q;
	logic              hit_flag_q;
	logic [1:0]        status_q;

	logic              accept;
	logic              start;
	logic              put_ok;
	logic [SIZE_W-1:0] size_clamped;
	logic              scan_end;
	logic              any_match;
	logic              finish;
	logic              res_load;
	cell_ctl_t         ctl;
	logic [ENTRIES-1:0] tok_vec;
	logic [ENTRIES-1:0] match_vec;

	assign in_ready     = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept       = in_valid && in_ready;
	assign start        = accept && (op == OP_GET);
	assign put_ok       = CW'(handle) < count_q;
	assign size_clamped = ({5'd0, size} > MAX_W) ? MAX_W[SIZE_W-1:0] : size;
	assign scan_end     = scan_idx_q == count_q;
	assign any_match    = |match_vec;
	assign finish       = (state_q == S_SCAN) && (scan_end || any_match);
	assign res_load     = (accept && (op == OP_PUT)) || finish;

	always_comb begin
		ctl.scan_clr = finish;
		ctl.take     = (state_q == S_SCAN) && !scan_end && any_match;
		ctl.wr_en    = (state_q == S_SCAN) && scan_end && (count_q != FULL_COUNT);
		ctl.free_en  = accept && (op == OP_PUT) && put_ok;
		ctl.req_size = req_q;
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic tok_in;
		if (i == 0) begin : g_head
			assign tok_in = start;
		end else begin : g_link
			assign tok_in = tok_vec[i-1];
		end
		skbp_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.wr_idx   (count_q[IW-1:0]),
			.free_idx (handle),
			.tok_i    (tok_in),
			.tok_o    (tok_vec[i]),
			.match_o  (match_vec[i])
		);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= size_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_idx_q  <= '0;
			count_q     <= '0;
			hit_q       <= '0;
			miss_q      <= '0;
			out_valid_q <= 1'b0;
			granted_q   <= '0;
			hit_flag_q  <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q    <= S_SCAN;
						scan_idx_q <= '0;
					end else if (accept) begin
						granted_q   <= '0;
						hit_flag_q  <= 1'b0;
						status_q    <= put_ok ? ST_OK : ST_NOT_FOUND;
					end
				end
				S_SCAN: begin
					priority if (scan_end) begin
						state_q     <= S_IDLE;
						hit_flag_q  <= 1'b0;
						if (count_q == FULL_COUNT) begin
							granted_q <= '0;
							status_q  <= ST_FULL;
						end else begin
							granted_q <= count_q[IW-1:0];
							status_q  <= ST_OK;
							count_q   <= count_q + CW'(1);
							miss_q    <= (miss_q == '1) ? miss_q : miss_q + 32'd1;
						end
					end else if (any_match) begin
						state_q     <= S_IDLE;
						granted_q   <= scan_idx_q[IW-1:0];
						hit_flag_q  <= 1'b1;
						status_q    <= ST_OK;
						hit_q       <= (hit_q == '1) ? hit_q : hit_q + 32'd1;
					end else begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign granted_handle = granted_q;
	assign hit            = hit_flag_q;
	assign status         = status_q;
	assign hit_total      = hit_q;
	assign miss_total     = miss_q;
	assign entries_used   = count_q;

	`SKBP_ASSERT(a_one_token, $onehot0(tok_vec))
	`SKBP_ASSERT(a_count_bound, count_q <= FULL_COUNT)
	`SKBP_ASSERT_IMP(a_scan_bound, state_q == S_SCAN, scan_idx_q <= count_q)
	`SKBP_ASSERT_IMP(a_hit_ok, out_valid_q && hit_flag_q, status_q == ST_OK)
	`SKBP_ASSERT_IMP(a_no_out_in_scan, state_q == S_SCAN, !out_valid_q)
endmodule
`default_nettype wire
